[rtl/core/c39_pkg.sv]
// Shared types, constants and table functions of the Code 39 full-ASCII encoder.
// Used by every module in rtl/core; depends on nothing.
package c39_pkg;

	localparam int QUIET_MULTIPLE_DEF = 10;
	localparam int QUEUE_DEPTH_DEF    = 2;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	localparam logic [1:0] KIND_QUIET = 2'd0;
	localparam logic [1:0] KIND_GUARD = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	localparam logic [1:0] REG_THIN  = 2'd0;
	localparam logic [1:0] REG_THICK = 2'd1;
	localparam logic [1:0] REG_LABEL = 2'd2;

	localparam logic [3:0] THIN_RST  = 4'd2;
	localparam logic [4:0] THICK_RST = 5'd5;
	localparam logic       LABEL_RST = 1'b1;

	localparam logic [6:0] CH_STAR = 7'h2A;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
	} char_word_t;

	typedef struct packed {
		logic [7:0] bar_width;
		logic       bar_dark;
		logic [1:0] bar_kind;
		logic       text_below;
		logic       label_valid;
		logic [6:0] label_char;
		logic [7:0] label_width;
		logic       last;
	} bar_word_t;

	typedef struct packed {
		logic [3:0] thin;
		logic [4:0] thick;
		logic       label_en;
	} cfg_t;

	typedef struct packed {
		logic       start;
		logic       post;
		logic       two;
		logic [6:0] sym0;
		logic [8:0] pat0;
		logic [6:0] sym1;
		logic [8:0] pat1;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// {first symbol, second symbol}; second is zero for a single symbol
	function automatic logic [13:0] full_ascii(input logic [7:0] c);
		logic [7:0] f;
		logic [7:0] sn;
		f  = 8'h00;
		sn = 8'h00;
		case (c) inside
			8'd0: begin
				f = 8'h25; sn = 8'h55;
			end
			[8'd1:8'd26]: begin
				f = 8'h24; sn = c + 8'd64;
			end
			[8'd27:8'd31]: begin
				f = 8'h25; sn = c + 8'd38;
			end
			8'd32, 8'd45, 8'd46, [8'd48:8'd57], [8'd65:8'd90]: begin
				f = c;
			end
			[8'd33:8'd44]: begin
				f = 8'h2F; sn = c + 8'd32;
			end
			8'd47: begin
				f = 8'h2F; sn = 8'h4F;
			end
			8'd58: begin
				f = 8'h2F; sn = 8'h5A;
			end
			[8'd59:8'd63]: begin
				f = 8'h25; sn = c + 8'd11;
			end
			8'd64: begin
				f = 8'h25; sn = 8'h56;
			end
			[8'd91:8'd95]: begin
				f = 8'h25; sn = c - 8'd16;
			end
			8'd96: begin
				f = 8'h25; sn = 8'h57;
			end
			[8'd97:8'd122]: begin
				f = 8'h2B; sn = c - 8'd32;
			end
			[8'd123:8'd127]: begin
				f = 8'h25; sn = c - 8'd43;
			end
			default: begin
				f = 8'h00; sn = 8'h00;
			end
		endcase
		return {f[6:0], sn[6:0]};
	endfunction

	// thick flags of the nine elements of one symbol, element 0 in bit 0
	function automatic logic [8:0] sym_pattern(input logic [6:0] c);
		logic [3:0] d;
		logic [1:0] s;
		logic [3:0] b;
		logic       plain;
		logic [8:0] p;
		d     = 4'd0;
		s     = 2'd0;
		plain = 1'b1;
		case (c) inside
			[7'h31:7'h39]: begin
				d = 4'(c - 7'h31); s = 2'd0;
			end
			7'h30: begin
				d = 4'd9; s = 2'd0;
			end
			[7'h41:7'h4A]: begin
				d = 4'(c - 7'h41); s = 2'd1;
			end
			[7'h4B:7'h54]: begin
				d = 4'(c - 7'h4B); s = 2'd2;
			end
			[7'h55:7'h5A]: begin
				d = 4'(c - 7'h55); s = 2'd3;
			end
			7'h2D: begin
				d = 4'd6; s = 2'd3;
			end
			7'h2E: begin
				d = 4'd7; s = 2'd3;
			end
			7'h20: begin
				d = 4'd8; s = 2'd3;
			end
			7'h2A: begin
				d = 4'd9; s = 2'd3;
			end
			default: begin
				plain = 1'b0;
			end
		endcase
		b = d + 4'd1;
		if (b >= 4'd7) b = b + 4'd1;
		if (b >= 4'd11) b = b + 4'd1;
		if (plain) begin
			p[0] = b[0];
			p[1] = (s == 2'd3);
			p[2] = b[1];
			p[3] = (s == 2'd0);
			p[4] = b[2];
			p[5] = (s == 2'd1);
			p[6] = b[3];
			p[7] = (s == 2'd2);
			p[8] = (b == 4'd1) || (b == 4'd2) || (b == 4'd4) || (b == 4'd8);
		end else begin
			p = 9'd0;
			p[1] = (c != 7'h25);
			p[3] = (c != 7'h2B);
			p[5] = (c != 7'h2F);
			p[7] = (c != 7'h24);
		end
		return p;
	endfunction

endpackage

[rtl/core/c39_front.sv]
// Front end: accepts input words and classifies them into symbol jobs.
// Depends on c39_pkg for word types and the full-ASCII and pattern tables.
module c39_front (
	input  logic                 char_valid,
	output logic                 char_stall,
	input  c39_pkg::char_word_t  char_word,
	input  c39_pkg::queue_stat_t queue_stat,
	output logic                 push,
	output c39_pkg::job_t        push_job
);

	logic [13:0] map;
	logic        keep;

	assign map        = c39_pkg::full_ascii(char_word.char_code);
	assign char_stall = queue_stat.full;

	always_comb begin
		push_job      = '0;
		keep          = 1'b0;
		push_job.sym0 = c39_pkg::CH_STAR;
		case (char_word.action)
			c39_pkg::ACT_START: begin
				keep           = 1'b1;
				push_job.start = 1'b1;
			end
			c39_pkg::ACT_DATA: begin
				keep          = !char_word.char_code[7];
				push_job.sym0 = map[13:7];
				push_job.sym1 = map[6:0];
				push_job.two  = (map[6:0] != 7'd0);
			end
			c39_pkg::ACT_STOP: begin
				keep          = 1'b1;
				push_job.post = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		push_job.pat0 = c39_pkg::sym_pattern(push_job.sym0);
		push_job.pat1 = c39_pkg::sym_pattern(push_job.sym1);
	end

	// drop words that produce no elements
	assign push = char_valid && !queue_stat.full && keep;

endmodule

[rtl/core/c39_queue.sv]
// Short job queue between the front end and the element sequencer.
// Depends on c39_pkg for the job and status types.
module c39_queue #(
	parameter int DEPTH = c39_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  c39_pkg::job_t        push_job,
	input  logic                 pop,
	output c39_pkg::job_t        pop_job,
	output c39_pkg::queue_stat_t queue_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	c39_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign pop_job          = mem_q[rptr_q];
	assign queue_stat.full  = (count_q == CW'(DEPTH));
	assign queue_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/core/c39_back.sv]
// Element sequencer: steps each job through quiet zones, guards and bars,
// one element per cycle into a registered output unless the output stalls. Depends on c39_pkg.
module c39_back #(
	parameter int QUIET_MULTIPLE = c39_pkg::QUIET_MULTIPLE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c39_pkg::cfg_t        cfg,
	input  c39_pkg::queue_stat_t queue_stat,
	output logic                 pop,
	input  c39_pkg::job_t        pop_job,
	output logic                 bar_valid,
	input  logic                 bar_stall,
	output c39_pkg::bar_word_t   bar_word
);

	localparam logic [1:0] PH_QPRE  = 2'd0;
	localparam logic [1:0] PH_SYM   = 2'd1;
	localparam logic [1:0] PH_QPOST = 2'd2;

	c39_pkg::job_t      cur_q;
	c39_pkg::bar_word_t bar_q, elem;
	logic               busy_q, color_q, seen_q, symi_q, bar_valid_q;
	logic [1:0]         phase_q;
	logic [3:0]         cnt_q, bar_idx;
	logic               adv, step, is_guard, sym_end, finish, black, take;
	logic [6:0]         sym_char;
	logic [8:0]         sym_pat;
	logic [7:0]         quiet_w, label_w;

	assign adv      = !bar_valid_q || !bar_stall;
	assign step     = busy_q && adv;
	assign sym_char = symi_q ? cur_q.sym1 : cur_q.sym0;
	assign sym_pat  = symi_q ? cur_q.pat1 : cur_q.pat0;
	assign is_guard = (phase_q == PH_SYM) && (cnt_q == 4'd0) && seen_q;
	assign bar_idx  = (cnt_q == 4'd0) ? 4'd0 : cnt_q - 4'd1;
	assign sym_end  = (phase_q == PH_SYM) && !is_guard && (bar_idx == 4'd8);
	assign finish   = (phase_q == PH_QPOST) ||
	                  (sym_end && !(!symi_q && cur_q.two) && !cur_q.post);
	assign black    = (phase_q == PH_QPRE) ? 1'b0 : color_q;
	assign take     = !queue_stat.empty && (!busy_q || (step && finish));
	assign pop      = take;
	assign quiet_w  = {4'd0, cfg.thin} * 8'(QUIET_MULTIPLE);
	assign label_w  = {3'd0, cfg.thick} * 8'd3 + {4'd0, cfg.thin} * 8'd6;

	always_comb begin
		elem          = '0;
		elem.bar_dark = black;
		elem.last     = finish;
		if (phase_q == PH_SYM && !is_guard) begin
			elem.bar_kind   = c39_pkg::KIND_DATA;
			elem.bar_width  = sym_pat[bar_idx] ? {3'd0, cfg.thick} : {4'd0, cfg.thin};
			elem.text_below = cfg.label_en;
			if (cfg.label_en && bar_idx == 4'd0) begin
				elem.label_valid = 1'b1;
				elem.label_char  = sym_char;
				elem.label_width = label_w;
			end
		end else if (is_guard) begin
			elem.bar_kind  = c39_pkg::KIND_GUARD;
			elem.bar_width = {4'd0, cfg.thin};
		end else begin
			elem.bar_kind  = c39_pkg::KIND_QUIET;
			elem.bar_width = quiet_w;
		end
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= pop_job;
		if (step) bar_q <= elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			color_q     <= 1'b0;
			seen_q      <= 1'b0;
			symi_q      <= 1'b0;
			phase_q     <= PH_QPRE;
			cnt_q       <= 4'd0;
			bar_valid_q <= 1'b0;
		end else begin
			if (adv) bar_valid_q <= busy_q;
			if (step) begin
				color_q <= ~black;
				if (phase_q == PH_QPRE) seen_q <= 1'b0;
				else if (phase_q == PH_SYM) seen_q <= 1'b1;
			end
			if (take) begin
				busy_q  <= 1'b1;
				phase_q <= pop_job.start ? PH_QPRE : PH_SYM;
				cnt_q   <= 4'd0;
				symi_q  <= 1'b0;
			end else if (step) begin
				case (phase_q)
					PH_QPRE: begin
						phase_q <= PH_SYM;
						cnt_q   <= 4'd0;
					end
					PH_SYM: begin
						if (is_guard) begin
							cnt_q <= 4'd1;
						end else if (sym_end) begin
							if (!symi_q && cur_q.two) begin
								symi_q <= 1'b1;
								cnt_q  <= 4'd0;
							end else if (cur_q.post) begin
								phase_q <= PH_QPOST;
							end
						end else begin
							cnt_q <= (cnt_q == 4'd0) ? 4'd2 : cnt_q + 4'd1;
						end
					end
					default: begin
						phase_q <= PH_QPOST;
					end
				endcase
				if (finish) busy_q <= 1'b0;
			end
		end
	end

	assign bar_valid = bar_valid_q;
	assign bar_word  = bar_q;

endmodule

[rtl/core/code39_full_ascii_encoder.sv]
// Code 39 full-ASCII encoder top level: APB registers, front end, job queue, sequencer.
// A word's first element passes the queue, the job register and the output register.
// Throughput: one element per cycle unless the output stalls, set by the sequencer's
// single output; elements per word: start 10, stop 10 or 11, character 9 to 20.
// Up to QUEUE_DEPTH classified words wait in the queue while the output stalls.
// Reset clears the queue, the sequencer and the registers (thin 2, thick 5, label 1).
module code39_full_ascii_encoder #(
	parameter int QUIET_MULTIPLE = c39_pkg::QUIET_MULTIPLE_DEF,
	parameter int QUEUE_DEPTH    = c39_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  c39_pkg::char_word_t char_word,
	output logic                bar_valid,
	input  logic                bar_stall,
	output c39_pkg::bar_word_t  bar_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	c39_pkg::cfg_t        cfg_q;
	c39_pkg::queue_stat_t queue_stat;
	c39_pkg::job_t        push_job, pop_job;
	logic                 push, pop;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thin     <= c39_pkg::THIN_RST;
			cfg_q.thick    <= c39_pkg::THICK_RST;
			cfg_q.label_en <= c39_pkg::LABEL_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				c39_pkg::REG_THIN:  cfg_q.thin     <= pwdata[3:0];
				c39_pkg::REG_THICK: cfg_q.thick    <= pwdata[4:0];
				c39_pkg::REG_LABEL: cfg_q.label_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		case (paddr[3:2])
			c39_pkg::REG_THIN:  prdata = {28'd0, cfg_q.thin};
			c39_pkg::REG_THICK: prdata = {27'd0, cfg_q.thick};
			c39_pkg::REG_LABEL: prdata = {31'd0, cfg_q.label_en};
			default:            prdata = 32'd0;
		endcase
	end

	c39_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.queue_stat (queue_stat),
		.push       (push),
		.push_job   (push_job)
	);

	c39_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.pop_job    (pop_job),
		.queue_stat (queue_stat)
	);

	c39_back #(
		.QUIET_MULTIPLE (QUIET_MULTIPLE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.queue_stat (queue_stat),
		.pop        (pop),
		.pop_job    (pop_job),
		.bar_valid  (bar_valid),
		.bar_stall  (bar_stall),
		.bar_word   (bar_word)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_stat.empty)
		else $error("job taken from an empty queue");

	a_label_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_word.label_valid |->
			bar_word.bar_kind == c39_pkg::KIND_DATA && bar_word.text_below)
		else $error("label mark outside a data element");

	a_guard_width: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_word.bar_kind == c39_pkg::KIND_GUARD |->
			bar_word.bar_width == {4'd0, cfg_q.thin} && !bar_word.text_below)
		else $error("guard gap with wrong width or text flag");

endmodule
